// ===== hw/rtl/mve_pkg.sv =====
package mve_pkg;

    // item kinds
    typedef enum logic [3:0] {
        OP_NIL      = 4'd0,
        OP_BOOL     = 4'd1,
        OP_SIGNED   = 4'd2,
        OP_UNSIGNED = 4'd3,
        OP_FLOAT    = 4'd4,
        OP_ARRAY    = 4'd5,
        OP_MAP      = 4'd6,
        OP_RAW      = 4'd7,
        OP_PAYLOAD  = 4'd8
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_ROOM    = 2'd1,
        ST_UNEXPECTED = 2'd2,
        ST_PENDING    = 2'd3
    } status_t;

    // configuration register map
    localparam int CFG_ADDR_W = 3;
    localparam logic CFG_IDX_CAPACITY = 1'b0;
    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;

    // result queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // format markers
    localparam logic [7:0] MK_NIL    = 8'hC0;
    localparam logic [7:0] MK_FALSE  = 8'hC2;
    localparam logic [7:0] MK_TRUE   = 8'hC3;
    localparam logic [7:0] MK_FLOAT  = 8'hCA;
    localparam logic [7:0] MK_UINT8  = 8'hCC;
    localparam logic [7:0] MK_UINT16 = 8'hCD;
    localparam logic [7:0] MK_UINT32 = 8'hCE;
    localparam logic [7:0] MK_INT8   = 8'hD0;
    localparam logic [7:0] MK_INT16  = 8'hD1;
    localparam logic [7:0] MK_INT32  = 8'hD2;
    localparam logic [7:0] MK_RAW8   = 8'hD9;
    localparam logic [7:0] MK_RAW16  = 8'hDA;
    localparam logic [7:0] MK_RAW32  = 8'hDB;
    localparam logic [7:0] MK_ARR16  = 8'hDC;
    localparam logic [7:0] MK_ARR32  = 8'hDD;
    localparam logic [7:0] MK_MAP16  = 8'hDE;
    localparam logic [7:0] MK_MAP32  = 8'hDF;
    localparam logic [3:0] MK_FIXARR = 4'h9;
    localparam logic [3:0] MK_FIXMAP = 4'h8;
    localparam logic [2:0] MK_FIXRAW = 3'b101;

    // encoded header, first byte in the top bits
    typedef struct packed {
        logic [39:0] hdr;
        logic [2:0]  count;
    } enc_t;

    // one unit of work for the back end
    typedef struct packed {
        logic [39:0] hdr;
        logic [2:0]  count;
        status_t     status;
    } job_t;

    function automatic enc_t encode_hdr(op_t op, logic [31:0] v);
        enc_t e;
        e.hdr   = '0;
        e.count = 3'd1;
        unique case (op)
            OP_NIL:
                e.hdr = {MK_NIL, 32'd0};
            OP_BOOL:
                e.hdr = {((v != 32'd0) ? MK_TRUE : MK_FALSE), 32'd0};
            OP_SIGNED:
            begin
                if (v >= 32'hFFFF_FFE0)
                begin
                    e.hdr = {v[7:0], 32'd0};
                end
                else if (v <= 32'h7F || v >= 32'hFFFF_FF80)
                begin
                    e.hdr = {MK_INT8, v[7:0], 24'd0};
                    e.count = 3'd2;
                end
                else if (v <= 32'h7FFF || v >= 32'hFFFF_8000)
                begin
                    e.hdr = {MK_INT16, v[15:0], 16'd0};
                    e.count = 3'd3;
                end
                else
                begin
                    e.hdr = {MK_INT32, v};
                    e.count = 3'd5;
                end
            end
            OP_UNSIGNED:
            begin
                if (v <= 32'h7F)
                begin
                    e.hdr = {v[7:0], 32'd0};
                end
                else if (v <= 32'hFF)
                begin
                    e.hdr = {MK_UINT8, v[7:0], 24'd0};
                    e.count = 3'd2;
                end
                else if (v <= 32'hFFFF)
                begin
                    e.hdr = {MK_UINT16, v[15:0], 16'd0};
                    e.count = 3'd3;
                end
                else
                begin
                    e.hdr = {MK_UINT32, v};
                    e.count = 3'd5;
                end
            end
            OP_FLOAT:
            begin
                e.hdr = {MK_FLOAT, v};
                e.count = 3'd5;
            end
            OP_ARRAY, OP_MAP:
            begin
                if (v <= 32'hF)
                begin
                    e.hdr = {((op == OP_ARRAY) ? MK_FIXARR : MK_FIXMAP), v[3:0], 32'd0};
                end
                else if (v <= 32'hFFFF)
                begin
                    e.hdr = {((op == OP_ARRAY) ? MK_ARR16 : MK_MAP16), v[15:0], 16'd0};
                    e.count = 3'd3;
                end
                else
                begin
                    e.hdr = {((op == OP_ARRAY) ? MK_ARR32 : MK_MAP32), v};
                    e.count = 3'd5;
                end
            end
            OP_RAW:
            begin
                if (v <= 32'h1F)
                begin
                    e.hdr = {MK_FIXRAW, v[4:0], 32'd0};
                end
                else if (v <= 32'hFF)
                begin
                    e.hdr = {MK_RAW8, v[7:0], 24'd0};
                    e.count = 3'd2;
                end
                else if (v <= 32'hFFFF)
                begin
                    e.hdr = {MK_RAW16, v[15:0], 16'd0};
                    e.count = 3'd3;
                end
                else
                begin
                    e.hdr = {MK_RAW32, v};
                    e.count = 3'd5;
                end
            end
            default:
                e.hdr = '0;
        endcase
        return e;
    endfunction

endpackage

// ===== hw/rtl/mve_if.sv =====
interface mve_item_if;
    logic        valid;
    logic        ready;
    logic [3:0]  opcode;
    logic [31:0] value;
    logic [7:0]  data_byte;

    modport source (output valid, output opcode, output value, output data_byte, input ready);
    modport sink (input valid, input opcode, input value, input data_byte, output ready);
endinterface

interface mve_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        last;
    logic [1:0]  status;
    logic [15:0] offset;

    modport source (output valid, output out_byte, output last, output status, output offset,
                    input ready);
    modport sink (input valid, input out_byte, input last, input status, input offset,
                  output ready);
endinterface

// ===== hw/rtl/msgpack_value_encoder.sv =====
// MessagePack value encoder. Each request on the item channel carries one value (nil, boolean,
// signed or unsigned integer, float bits, array/map header, raw header or one raw payload byte)
// and produces one to five result requests, one encoded byte each, the final one marked by last.
// The front end takes an item every cycle while its four-entry job queue has room; the back end
// drives the result channel at one byte per cycle while the receiver is ready, and an item has
// 1 to 5 bytes, 5 for the widest headers. The first byte of an item is offered once the item
// has passed through the job queue and been loaded into the back end's byte registers. Space is
// checked against the capacity register (APB offset 0, reset 65535); writing it clears the
// byte offset. An item that does not fit, a payload byte with nothing owed, or any other item
// while raw payload is owed gives one result with an error status and a zero byte, and leaves
// the state as it was. Opcodes 9 to 15 are taken and dropped.
module msgpack_value_encoder #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    mve_item_if.sink                       item,
    mve_result_if.source                   result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mve_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import mve_pkg::*;

    logic                   cap_wr;
    logic [15:0]            capacity;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_not_full;
    logic                   q_not_empty;
    job_t                   push_job;
    job_t                   head_job;
    logic [OFFSET_BITS-1:0] push_off;
    logic [OFFSET_BITS-1:0] head_off;

    // register port
    assign pready = 1'b1;
    assign cap_wr = psel & penable & pwrite & pready & (paddr[2] == CFG_IDX_CAPACITY);
    assign prdata = (paddr[2] == CFG_IDX_CAPACITY) ? {16'd0, capacity} : 32'd0;

    mve_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cap_wr   (cap_wr),
        .cap_data (pwdata[15:0]),
        .capacity (capacity),
        .q_ready  (q_not_full),
        .q_push   (q_push),
        .q_job    (push_job),
        .q_off    (push_off)
    );

    mve_queue #(.OFFSET_BITS(OFFSET_BITS)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .push_off  (push_off),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_job  (head_job),
        .head_off  (head_off)
    );

    mve_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_not_empty),
        .q_job   (head_job),
        .q_off   (head_off),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

// ===== hw/rtl/mve_front.sv =====
module mve_front #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    mve_item_if.sink               item,
    input  logic                   cap_wr,
    input  logic [15:0]            cap_data,
    output logic [15:0]            capacity,
    input  logic                   q_ready,
    output logic                   q_push,
    output mve_pkg::job_t          q_job,
    output logic [OFFSET_BITS-1:0] q_off
);
    import mve_pkg::*;

    logic [15:0]            capacity_reg;
    logic [OFFSET_BITS-1:0] byte_offset_reg;
    logic [OFFSET_BITS-1:0] byte_offset_next;
    logic [31:0]            payload_left_reg;
    logic [31:0]            payload_left_next;
    op_t                    op;
    enc_t                   enc;
    logic [32:0]            need;
    logic [33:0]            room_sum;
    logic [33:0]            one_sum;
    logic                   has_job;
    logic                   accept;

    assign item.ready = q_ready;
    assign accept     = item.valid & item.ready;
    assign q_push     = accept & has_job;
    assign capacity   = capacity_reg;

    // header encoding and space needed
    assign op       = op_t'(item.opcode);
    assign enc      = encode_hdr(op, item.value);
    assign need     = 33'(enc.count) + ((op == OP_RAW) ? {1'b0, item.value} : 33'd0);
    assign room_sum = 34'(byte_offset_reg) + 34'(need);
    assign one_sum  = 34'(byte_offset_reg) + 34'd1;

    // classify the request and work out the state update
    always_comb
    begin
        has_job           = 1'b0;
        q_job.hdr         = '0;
        q_job.count       = 3'd1;
        q_job.status      = ST_OK;
        q_off             = byte_offset_reg;
        byte_offset_next  = byte_offset_reg;
        payload_left_next = payload_left_reg;
        priority if (op == OP_PAYLOAD)
        begin
            has_job = 1'b1;
            priority if (payload_left_reg == 32'd0)
            begin
                q_job.status = ST_UNEXPECTED;
            end
            else if (one_sum > 34'(capacity_reg))
            begin
                q_job.status = ST_NO_ROOM;
            end
            else
            begin
                q_job.hdr         = {item.data_byte, 32'd0};
                byte_offset_next  = byte_offset_reg + OFFSET_BITS'(1);
                q_off             = byte_offset_next;
                payload_left_next = payload_left_reg - 32'd1;
            end
        end
        else if (item.opcode > OP_PAYLOAD)
        begin
            has_job = 1'b0;
        end
        else
        begin
            has_job = 1'b1;
            priority if (payload_left_reg != 32'd0)
            begin
                q_job.status = ST_PENDING;
            end
            else if (room_sum > 34'(capacity_reg))
            begin
                q_job.status = ST_NO_ROOM;
            end
            else
            begin
                q_job.hdr        = enc.hdr;
                q_job.count      = enc.count;
                byte_offset_next = byte_offset_reg + OFFSET_BITS'(enc.count);
                q_off            = byte_offset_reg + OFFSET_BITS'(1);
                if (op == OP_RAW)
                begin
                    payload_left_next = item.value;
                end
            end
        end
    end

    // capacity, offset and owed payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg     <= CAPACITY_RESET;
            byte_offset_reg  <= '0;
            payload_left_reg <= '0;
        end
        else if (cap_wr)
        begin
            capacity_reg    <= cap_data;
            byte_offset_reg <= '0;
        end
        else if (accept)
        begin
            byte_offset_reg  <= byte_offset_next;
            payload_left_reg <= payload_left_next;
        end
    end

endmodule

// ===== hw/rtl/mve_queue.sv =====
module mve_queue #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  mve_pkg::job_t          push_job,
    input  logic [OFFSET_BITS-1:0] push_off,
    output logic                   not_full,
    input  logic                   pop,
    output logic                   not_empty,
    output mve_pkg::job_t          head_job,
    output logic [OFFSET_BITS-1:0] head_off
);
    import mve_pkg::*;

    job_t                   job_mem [QUEUE_DEPTH];
    logic [OFFSET_BITS-1:0] off_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push;
    logic                   do_pop;

    assign not_full  = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push & not_full;
    assign do_pop    = pop & not_empty;
    assign head_job  = job_mem[rd_ptr_reg];
    assign head_off  = off_mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            job_mem[wr_ptr_reg] <= push_job;
            off_mem[wr_ptr_reg] <= push_off;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + QUEUE_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - QUEUE_CNT_W'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/mve_back.sv =====
module mve_back #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  mve_pkg::job_t          q_job,
    input  logic [OFFSET_BITS-1:0] q_off,
    output logic                   q_pop,
    mve_result_if.source           result
);
    import mve_pkg::*;

    logic                   busy_reg;
    logic [39:0]            hdr_reg;
    logic [2:0]             left_reg;
    status_t                status_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [31:0]            off_wide;
    logic                   take;
    logic                   is_last;

    assign take    = result.valid & result.ready;
    assign is_last = (left_reg == 3'd1);
    assign q_pop   = q_valid & (~busy_reg | (take & is_last));

    // output straight from the byte registers
    assign off_wide        = 32'(off_reg);
    assign result.valid    = busy_reg;
    assign result.out_byte = hdr_reg[39:32];
    assign result.last     = is_last;
    assign result.status   = status_reg;
    assign result.offset   = off_wide[15:0];

    // control: busy flag and bytes left
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            left_reg <= '0;
        end
        else if (q_pop)
        begin
            busy_reg <= 1'b1;
            left_reg <= q_job.count;
        end
        else if (take)
        begin
            busy_reg <= ~is_last;
            left_reg <= left_reg - 3'd1;
        end
    end

    // payload: shift out one byte per request
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            hdr_reg    <= q_job.hdr;
            status_reg <= q_job.status;
            off_reg    <= q_off;
        end
        else if (take)
        begin
            hdr_reg <= {hdr_reg[31:0], 8'd0};
            off_reg <= off_reg + OFFSET_BITS'(1);
        end
    end

endmodule

// ===== hw/rtl/mve_checker.sv =====
module mve_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [7:0]  res_byte,
    input logic        res_last,
    input logic [1:0]  res_status,
    input logic [15:0] res_offset
);
    import mve_pkg::*;

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_byte) && $stable(res_last)
            && $stable(res_status) && $stable(res_offset))
        else $error("result payload changed while stalled");

    // an error is a single zero byte
    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status != ST_OK |-> res_last && res_byte == 8'd0)
        else $error("error result not a single zero byte");

    // the bytes of one item follow without a gap
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_last |=> res_valid)
        else $error("gap inside an encoded value");

endmodule

bind msgpack_value_encoder mve_checker u_mve_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_byte   (result.out_byte),
    .res_last   (result.last),
    .res_status (result.status),
    .res_offset (result.offset)
);

// ===== bench/tb_msgpack_value_encoder.sv =====
module tb_msgpack_value_encoder;
    import mve_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_IDLE      = 14;

    // register addresses; only the first register exists
    localparam logic [CFG_ADDR_W-1:0] ADDR_CAPACITY = {CFG_IDX_CAPACITY, 2'b00};
    localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE    = 3'd4;

    // opcodes the block drops
    localparam logic [3:0] OP_UNDEF_LO = 4'd9;
    localparam logic [3:0] OP_UNDEF_HI = 4'd15;

    // messagepack format bytes
    localparam logic [7:0] FMT_NIL    = 8'hC0;
    localparam logic [7:0] FMT_FALSE  = 8'hC2;
    localparam logic [7:0] FMT_TRUE   = 8'hC3;
    localparam logic [7:0] FMT_FLOAT  = 8'hCA;
    localparam logic [7:0] FMT_UINT8  = 8'hCC;
    localparam logic [7:0] FMT_UINT16 = 8'hCD;
    localparam logic [7:0] FMT_UINT32 = 8'hCE;
    localparam logic [7:0] FMT_INT8   = 8'hD0;
    localparam logic [7:0] FMT_INT16  = 8'hD1;
    localparam logic [7:0] FMT_INT32  = 8'hD2;
    localparam logic [7:0] FMT_RAW8   = 8'hD9;
    localparam logic [7:0] FMT_RAW16  = 8'hDA;
    localparam logic [7:0] FMT_RAW32  = 8'hDB;
    localparam logic [7:0] FMT_ARR16  = 8'hDC;
    localparam logic [7:0] FMT_ARR32  = 8'hDD;
    localparam logic [7:0] FMT_MAP16  = 8'hDE;
    localparam logic [7:0] FMT_MAP32  = 8'hDF;
    localparam logic [7:0] FMT_FIXARR = 8'h90;
    localparam logic [7:0] FMT_FIXMAP = 8'h80;
    localparam logic [7:0] FMT_FIXRAW = 8'hA0;

    typedef struct {
        logic [3:0]  opcode;
        logic [31:0] value;
        logic [7:0]  data_byte;
        int          gap;
    } enc_item_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        status_t     status;
        logic [15:0] offset;
    } enc_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mve_item_if   item_ch();
    mve_result_if res_ch();

    msgpack_value_encoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // encoder state as predicted
    logic [15:0] enc_capacity = CAPACITY_RESET;
    logic [15:0] enc_offset = 16'd0;
    logic [31:0] payload_owed = 32'd0;

    enc_item_t item_backlog[$];
    enc_byte_t expected_bytes[$];
    enc_item_t next_item;
    enc_byte_t want;

    int  gap_count = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    int  hold_reqs = 0;
    int  hold_served = 0;
    bit  src_idle_on = 1'b0;
    bit  sink_idle_on = 1'b0;
    int  error_count = 0;
    int  items_taken = 0;
    int  bytes_checked = 0;
    int  cap_writes = 0;
    int  cycle_count = 0;
    int  status_tally[4] = '{0, 0, 0, 0};

    always #5 clk = ~clk;

    // push one expected result byte at the current offset
    function automatic void push_byte(logic [7:0] b, logic l, status_t s);
        enc_byte_t e;
        e.data = b;
        e.last = l;
        e.status = s;
        e.offset = enc_offset;
        expected_bytes.push_back(e);
    endfunction

    // work out the bytes one accepted request produces
    function automatic void predict_item(logic [3:0] opc, logic [31:0] v, logic [7:0] db);
        logic [39:0] hv;
        logic [33:0] need;
        int nb;
        int k;
        hv = '0;
        nb = 1;
        if (opc > OP_PAYLOAD)
            return;
        if (opc == OP_PAYLOAD)
        begin
            if (payload_owed == 32'd0)
                push_byte(8'h00, 1'b1, ST_UNEXPECTED);
            else if (34'(enc_offset) + 34'd1 > 34'(enc_capacity))
                push_byte(8'h00, 1'b1, ST_NO_ROOM);
            else
            begin
                enc_offset++;
                payload_owed--;
                push_byte(db, 1'b1, ST_OK);
            end
            return;
        end
        if (payload_owed != 32'd0)
        begin
            push_byte(8'h00, 1'b1, ST_PENDING);
            return;
        end
        case (opc)
            OP_NIL:
                hv = {FMT_NIL, 32'd0};
            OP_BOOL:
                hv = {((v != 32'd0) ? FMT_TRUE : FMT_FALSE), 32'd0};
            OP_SIGNED:
            begin
                if (v >= 32'hFFFF_FFE0)
                    hv = {v[7:0], 32'd0};
                else if (v <= 32'h7F || v >= 32'hFFFF_FF80)
                begin
                    hv = {FMT_INT8, v[7:0], 24'd0};
                    nb = 2;
                end
                else if (v <= 32'h7FFF || v >= 32'hFFFF_8000)
                begin
                    hv = {FMT_INT16, v[15:0], 16'd0};
                    nb = 3;
                end
                else
                begin
                    hv = {FMT_INT32, v};
                    nb = 5;
                end
            end
            OP_UNSIGNED:
            begin
                if (v <= 32'h7F)
                    hv = {v[7:0], 32'd0};
                else if (v <= 32'hFF)
                begin
                    hv = {FMT_UINT8, v[7:0], 24'd0};
                    nb = 2;
                end
                else if (v <= 32'hFFFF)
                begin
                    hv = {FMT_UINT16, v[15:0], 16'd0};
                    nb = 3;
                end
                else
                begin
                    hv = {FMT_UINT32, v};
                    nb = 5;
                end
            end
            OP_FLOAT:
            begin
                hv = {FMT_FLOAT, v};
                nb = 5;
            end
            OP_ARRAY, OP_MAP:
            begin
                if (v <= 32'hF)
                    hv = {((opc == OP_ARRAY) ? FMT_FIXARR : FMT_FIXMAP) | v[7:0], 32'd0};
                else if (v <= 32'hFFFF)
                begin
                    hv = {((opc == OP_ARRAY) ? FMT_ARR16 : FMT_MAP16), v[15:0], 16'd0};
                    nb = 3;
                end
                else
                begin
                    hv = {((opc == OP_ARRAY) ? FMT_ARR32 : FMT_MAP32), v};
                    nb = 5;
                end
            end
            default:
            begin
                if (v <= 32'h1F)
                    hv = {FMT_FIXRAW | v[7:0], 32'd0};
                else if (v <= 32'hFF)
                begin
                    hv = {FMT_RAW8, v[7:0], 24'd0};
                    nb = 2;
                end
                else if (v <= 32'hFFFF)
                begin
                    hv = {FMT_RAW16, v[15:0], 16'd0};
                    nb = 3;
                end
                else
                begin
                    hv = {FMT_RAW32, v};
                    nb = 5;
                end
            end
        endcase
        // a raw header reserves room for its whole payload
        need = 34'(nb) + ((opc == OP_RAW) ? 34'(v) : 34'd0);
        if (34'(enc_offset) + need > 34'(enc_capacity))
        begin
            push_byte(8'h00, 1'b1, ST_NO_ROOM);
            return;
        end
        for (k = 0; k < nb; k++)
        begin
            enc_offset++;
            push_byte(hv[39 - 8 * k -: 8], (k == nb - 1), ST_OK);
        end
        if (opc == OP_RAW)
            payload_owed = v;
    endfunction

    // random value spread over the size classes of each kind
    function automatic logic [31:0] pick_value(logic [3:0] opc);
        logic [31:0] w;
        int cls;
        w = $urandom;
        cls = $urandom_range(0, 3);
        case (opc)
            OP_BOOL:
                return (cls == 0) ? 32'd0 : (w >> $urandom_range(0, 31));
            OP_SIGNED:
                case (cls)
                    0: return 32'hFFFF_FFE0 | {27'd0, w[4:0]};
                    1: return {{24{w[7]}}, w[7:0]};
                    2: return {{16{w[15]}}, w[15:0]};
                    default: return w;
                endcase
            OP_UNSIGNED:
                case (cls)
                    0: return {25'd0, w[6:0]};
                    1: return {24'd0, w[7:0]};
                    2: return {16'd0, w[15:0]};
                    default: return w;
                endcase
            OP_ARRAY, OP_MAP:
                case (cls)
                    0, 1: return {28'd0, w[3:0]};
                    2: return {16'd0, w[15:0]};
                    default: return w;
                endcase
            default:
                return w;
        endcase
    endfunction

    task automatic add_item(logic [3:0] opc, logic [31:0] v, logic [7:0] db);
        enc_item_t it;
        it.opcode = opc;
        it.value = v;
        it.data_byte = db;
        it.gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        item_backlog.push_back(it);
    endtask

    task automatic add_plain();
        logic [3:0] opc;
        opc = 4'($urandom_range(OP_NIL, OP_MAP));
        add_item(opc, pick_value(opc), 8'($urandom));
    endtask

    // raw strings with their payloads, mixed with other kinds and some noise;
    // a header that surely cannot fit gets no payload
    task automatic queue_random(int count, logic [15:0] cap);
        int made;
        int owed;
        int pick;
        int lc;
        logic [31:0] len;
        made = 0;
        owed = 0;
        while (made < count || owed > 0)
        begin
            pick = $urandom_range(0, 99);
            if (owed > 0)
            begin
                if (pick < 3)
                    add_plain();
                else if (pick == 3)
                    add_item(OP_RAW, 32'd0, 8'($urandom));
                else if (pick < 6)
                    add_item(4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI)), $urandom,
                             8'($urandom));
                else
                begin
                    add_item(OP_PAYLOAD, $urandom, 8'($urandom));
                    owed--;
                end
                if (pick >= 6 || pick < 4)
                    made++;
            end
            else if (pick < 15)
            begin
                lc = $urandom_range(0, 19);
                if (lc < 14)
                    len = $urandom_range(0, 31);
                else if (lc < 18)
                    len = $urandom_range(32, 40);
                else if (cap < 16'd259)
                    len = $urandom_range(256, 65535);
                else
                    len = $urandom | 32'h0001_0000;
                add_item(OP_RAW, len, 8'($urandom));
                if (lc < 18)
                    owed = len;
                made++;
            end
            else if (pick < 19)
            begin
                add_item(OP_PAYLOAD, $urandom, 8'($urandom));
                made++;
            end
            else if (pick < 22)
                add_item(4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI)), $urandom, 8'($urandom));
            else
            begin
                add_plain();
                made++;
            end
        end
    endtask

    task automatic set_idling(bit src, bit sink);
        @(negedge clk);
        src_idle_on = src;
        sink_idle_on = sink;
    endtask

    // wait until every request is taken and every byte has come back
    task automatic drain();
        do
            @(negedge clk);
        while (item_backlog.size() != 0 || item_ch.valid || expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // write capacity, which also clears the offset, then read it back
    task automatic set_capacity(logic [15:0] cap);
        apb_write(ADDR_CAPACITY, {16'($urandom), cap});
        enc_capacity = cap;
        enc_offset = 16'd0;
        cap_writes++;
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        paddr <= ADDR_CAPACITY;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata[15:0] !== cap)
        begin
            $display("%0t: capacity readback mismatch, expected %04h got %04h",
                     $time, cap, prdata[15:0]);
            error_count++;
        end
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // request driver: each request waits out its own gap before it is offered
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            gap_count = 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                predict_item(item_ch.opcode, item_ch.value, item_ch.data_byte);
                items_taken++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (item_backlog.size() != 0 && gap_count >= item_backlog[0].gap)
                begin
                    next_item = item_backlog.pop_front();
                    item_ch.valid <= 1'b1;
                    item_ch.opcode <= next_item.opcode;
                    item_ch.value <= next_item.value;
                    item_ch.data_byte <= next_item.data_byte;
                    gap_count = 0;
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                    if (item_backlog.size() != 0)
                        gap_count++;
                end
            end
        end
    end

    // result monitor: compares each byte with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                bytes_checked++;
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: result with nothing expected, got byte %02h status %0d",
                             $time, res_ch.out_byte, res_ch.status);
                    error_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    status_tally[want.status]++;
                    if (res_ch.out_byte !== want.data)
                    begin
                        $display("%0t: out_byte mismatch, expected %02h got %02h",
                                 $time, want.data, res_ch.out_byte);
                        error_count++;
                    end
                    if (res_ch.last !== want.last)
                    begin
                        $display("%0t: last mismatch, expected %0b got %0b",
                                 $time, want.last, res_ch.last);
                        error_count++;
                    end
                    if (res_ch.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %s got %0d",
                                 $time, want.status.name(), res_ch.status);
                        error_count++;
                    end
                    if (res_ch.offset !== want.offset)
                    begin
                        $display("%0t: offset mismatch, expected %0d got %0d",
                                 $time, want.offset, res_ch.offset);
                        error_count++;
                    end
                end
                stall_left = sink_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (hold_served != hold_reqs)
            begin
                hold_served = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.opcode = OP_NIL;
        item_ch.value = 32'd0;
        item_ch.data_byte = 8'd0;
        res_ch.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = 32'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // largest capacity, and a write to an address with no register
        set_capacity(16'hFFFF);
        apb_write(ADDR_SPARE, $urandom);

        // directed: every kind at its size boundaries
        set_idling(1'b1, 1'b1);
        add_item(OP_NIL, 32'd0, 8'hFF);
        add_item(OP_BOOL, 32'd0, 8'h00);
        add_item(OP_BOOL, 32'h8000_0000, 8'h00);
        add_item(OP_SIGNED, 32'hFFFF_FFE0, 8'h00);
        add_item(OP_SIGNED, 32'hFFFF_FFDF, 8'h00);
        add_item(OP_SIGNED, 32'h0000_007F, 8'h00);
        add_item(OP_SIGNED, 32'hFFFF_8000, 8'h00);
        add_item(OP_SIGNED, 32'h8000_0000, 8'h00);
        add_item(OP_UNSIGNED, 32'h0000_007F, 8'h00);
        add_item(OP_UNSIGNED, 32'h0000_00FF, 8'h00);
        add_item(OP_UNSIGNED, 32'h0000_FFFF, 8'h00);
        add_item(OP_UNSIGNED, 32'hFFFF_FFFF, 8'h00);
        add_item(OP_FLOAT, 32'hFFFF_FFFF, 8'h00);
        add_item(OP_ARRAY, 32'h0000_000F, 8'h00);
        add_item(OP_MAP, 32'h0001_0000, 8'h00);
        add_item(OP_RAW, 32'd2, 8'h00);
        add_item(OP_PAYLOAD, 32'd0, 8'h00);
        add_item(OP_PAYLOAD, 32'hFFFF_FFFF, 8'hFF);
        // stray payload byte, then another kind while payload is owed
        add_item(OP_PAYLOAD, 32'd0, 8'h5A);
        add_item(OP_RAW, 32'd1, 8'h00);
        add_item(OP_NIL, 32'd0, 8'h00);
        add_item(OP_PAYLOAD, 32'd0, 8'hA5);
        // length that can never fit, and a dropped opcode
        add_item(OP_RAW, 32'hFFFF_FFFF, 8'h00);
        add_item(OP_UNDEF_HI, 32'hFFFF_FFFF, 8'hFF);
        add_item(OP_RAW, 32'd3, 8'h00);
        add_item(OP_PAYLOAD, 32'd0, 8'h11);
        drain();

        // payload byte after capacity shrank to zero
        set_capacity(16'd0);
        add_item(OP_PAYLOAD, 32'd0, 8'h22);
        add_item(OP_NIL, 32'd0, 8'h00);
        drain();
        set_capacity(16'hFFFF);
        add_item(OP_PAYLOAD, 32'd0, 8'h33);
        add_item(OP_PAYLOAD, 32'd0, 8'h44);
        drain();

        // raw8 header with its payload exactly filling the buffer, then one byte short
        set_capacity(16'd34);
        add_item(OP_RAW, 32'd32, 8'h00);
        repeat (32) add_item(OP_PAYLOAD, $urandom, 8'($urandom));
        add_item(OP_UNSIGNED, 32'd0, 8'h00);
        drain();
        set_capacity(16'd33);
        add_item(OP_RAW, 32'd32, 8'h00);
        add_item(OP_NIL, 32'd0, 8'h00);
        drain();

        // random phases over several capacities and idling mixes
        set_capacity(16'hFFFF);
        queue_random(10, 16'hFFFF);
        drain();
        set_capacity(16'hFFFF);
        set_idling(1'b0, 1'b0);
        queue_random(10, 16'hFFFF);
        drain();
        set_capacity(16'd300);
        set_idling(1'b1, 1'b0);
        queue_random(10, 16'd300);
        drain();
        set_capacity(16'd60);
        set_idling(1'b0, 1'b1);
        queue_random(5, 16'd60);
        drain();
        set_capacity(16'd0);
        set_idling(1'b1, 1'b1);
        queue_random(5, 16'd0);
        drain();
        set_capacity(16'd1000);
        queue_random(10, 16'd1000);
        drain();

        // long receiver hold while a raw16 string streams in back to back
        set_capacity(16'hFFFF);
        set_idling(1'b0, 1'b1);
        add_item(OP_RAW, 32'd256, 8'h00);
        repeat (256) add_item(OP_PAYLOAD, $urandom, 8'($urandom));
        queue_random(5, 16'hFFFF);
        @(negedge clk);
        hold_reqs++;
        drain();

        $display("covered %0d requests, %0d result bytes, %0d capacity settings",
                 items_taken, bytes_checked, cap_writes);
        $display("error results: %0d no room, %0d stray payload, %0d payload owed",
                 status_tally[ST_NO_ROOM], status_tally[ST_UNEXPECTED],
                 status_tally[ST_PENDING]);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/mve_pkg.sv
hw/rtl/mve_if.sv
hw/rtl/mve_front.sv
hw/rtl/mve_queue.sv
hw/rtl/mve_back.sv
hw/rtl/msgpack_value_encoder.sv
hw/rtl/mve_checker.sv
bench/tb_msgpack_value_encoder.sv
